// ----- rtl/msb_first_bit_field_reader_top_macros.svh -----
// ----------------------------------------------------------------------------
// MSB-first bit field reader: assertion macros
// Implication checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_FIELD_READER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_READER_TOP_MACROS_SVH

// Same-cycle implication.
`define MFBR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MFBR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mfbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MSB-first bit field reader: package
// Field widths, command and status codes shared by the interfaces and RTL.
// ----------------------------------------------------------------------------
package mfbr_pkg;

  localparam int MAX_FIELD_BITS = 64;
  localparam int POSITION_BITS  = 40;
  localparam int OUT_POS_BITS   = 40;
  localparam int CMD_BITS       = 2;
  localparam int BYTE_BITS      = 8;
  localparam int COUNT_BITS     = 7;
  localparam int STATUS_BITS    = 3;
  localparam int LEFT_BITS      = 4;

  typedef logic [CMD_BITS-1:0]       cmd_t;
  typedef logic [BYTE_BITS-1:0]      byte_t;
  typedef logic [COUNT_BITS-1:0]     count_t;
  typedef logic [STATUS_BITS-1:0]    status_t;
  typedef logic [MAX_FIELD_BITS-1:0] field_t;
  typedef logic [OUT_POS_BITS-1:0]   out_pos_t;
  typedef logic [POSITION_BITS-1:0]  pos_t;
  typedef logic [LEFT_BITS-1:0]      left_t;

  localparam cmd_t CMD_BYTE    = 2'd0;
  localparam cmd_t CMD_REQUEST = 2'd1;
  localparam cmd_t CMD_END     = 2'd2;
  localparam cmd_t CMD_NONE    = 2'd3;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_WIDTH = 3'd1;
  localparam status_t ST_TRUNCATED = 3'd2;
  localparam status_t ST_STREAM    = 3'd3;
  localparam status_t ST_DROPPED   = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/mfbr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MSB-first bit field reader: channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface mfbr_in_if;
  import mfbr_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  byte_t  byte_value;
  count_t bit_count;
  logic   stream_failed;

  modport source (output valid, command, byte_value, bit_count, stream_failed,
                  input ready);
  modport sink   (input valid, command, byte_value, bit_count, stream_failed,
                  output ready);
endinterface

interface mfbr_out_if;
  import mfbr_pkg::*;

  logic     valid;
  logic     ready;
  field_t   field_value;
  status_t  status;
  out_pos_t bit_position;

  modport source (output valid, field_value, status, bit_position, input ready);
  modport sink   (input valid, field_value, status, bit_position, output ready);
endinterface

`default_nettype wire

// ----- rtl/msb_first_bit_field_reader_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "msb_first_bit_field_reader_top_macros.svh"
// ----------------------------------------------------------------------------
// MSB-first bit field reader
// Byte cache drained one bit per cycle into a field shift register.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | command, byte_value, bit_count, stream_failed
//  out_ch   | out | valid/ready      | field_value, status, bit_position
//
//  A word is taken in the idle state. A byte or request that feeds a
//  pending field moves bits out of the byte cache (up to 8), checks
//  completion and, once done, emits. Other words stay idle or pass
//  through the emit state. The result sits in an output register; a new
//  word is taken while it waits, and a second result stalls until the first
//  is taken. Reset (rst_n low, synchronous) empties cache and request.
// ----------------------------------------------------------------------------
module msb_first_bit_field_reader_top (
  input  wire             clk,
  input  wire             rst_n,
  mfbr_in_if.sink         in_ch,
  mfbr_out_if.source      out_ch
);
  import mfbr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DRAIN = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  byte_t      cached_byte_r, cached_byte_nxt;
  left_t      bits_left_r, bits_left_nxt;
  count_t     pending_width_r, pending_width_nxt;
  count_t     bits_gathered_r, bits_gathered_nxt;
  field_t     field_accum_r, field_accum_nxt;
  pos_t       consumed_r, consumed_nxt;
  status_t    res_status_r, res_status_nxt;

  logic       out_valid_r, out_valid_nxt;
  field_t     out_field_r, out_field_nxt;
  status_t    out_status_r, out_status_nxt;
  out_pos_t   out_pos_r, out_pos_nxt;

  logic accept;
  logic out_free;
  logic bad_width;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign bad_width          = (in_ch.bit_count == '0) ||
                              (in_ch.bit_count > COUNT_BITS'(MAX_FIELD_BITS));

  assign out_ch.valid        = out_valid_r;
  assign out_ch.field_value  = out_field_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.bit_position = out_pos_r;

  always_comb begin
    state_nxt         = state_r;
    cached_byte_nxt   = cached_byte_r;
    bits_left_nxt     = bits_left_r;
    pending_width_nxt = pending_width_r;
    bits_gathered_nxt = bits_gathered_r;
    field_accum_nxt   = field_accum_r;
    consumed_nxt      = consumed_r;
    res_status_nxt    = res_status_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_field_nxt     = out_field_r;
    out_status_nxt    = out_status_r;
    out_pos_nxt       = out_pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_ch.command)
            CMD_BYTE: begin
              if (bits_left_r != '0) begin
                res_status_nxt = ST_DROPPED;
                state_nxt      = S_EMIT;
              end else begin
                cached_byte_nxt = in_ch.byte_value;
                bits_left_nxt   = LEFT_BITS'(BYTE_BITS);
                if (pending_width_r != '0) begin
                  state_nxt = S_DRAIN;
                end
              end
            end
            CMD_REQUEST: begin
              if (bad_width || pending_width_r != '0) begin
                res_status_nxt = ST_BAD_WIDTH;
                state_nxt      = S_EMIT;
              end else begin
                pending_width_nxt = in_ch.bit_count;
                bits_gathered_nxt = '0;
                field_accum_nxt   = '0;
                state_nxt         = S_DRAIN;
              end
            end
            CMD_END: begin
              if (pending_width_r != '0) begin
                // Drop the partial field; consumed bits stay counted.
                pending_width_nxt = '0;
                bits_gathered_nxt = '0;
                field_accum_nxt   = '0;
                res_status_nxt    = in_ch.stream_failed ? ST_STREAM : ST_TRUNCATED;
                state_nxt         = S_EMIT;
              end
            end
            CMD_NONE: ;
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        if (bits_gathered_r < pending_width_r && bits_left_r != '0) begin
          // Shift the cache MSB into the low end of the field.
          field_accum_nxt   = {field_accum_r[MAX_FIELD_BITS-2:0], cached_byte_r[BYTE_BITS-1]};
          cached_byte_nxt   = {cached_byte_r[BYTE_BITS-2:0], 1'b0};
          bits_left_nxt     = bits_left_r - 1'b1;
          bits_gathered_nxt = bits_gathered_r + 1'b1;
          consumed_nxt      = consumed_r + 1'b1;
        end else if (bits_gathered_r >= pending_width_r) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_field_nxt  = (res_status_r == ST_OK) ? field_accum_r : '0;
          out_status_nxt = res_status_r;
          out_pos_nxt    = OUT_POS_BITS'(consumed_r);
          if (res_status_r == ST_OK) begin
            pending_width_nxt = '0;
            bits_gathered_nxt = '0;
            field_accum_nxt   = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cached_byte_r   <= '0;
      bits_left_r     <= '0;
      pending_width_r <= '0;
      bits_gathered_r <= '0;
      field_accum_r   <= '0;
      consumed_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      cached_byte_r   <= cached_byte_nxt;
      bits_left_r     <= bits_left_nxt;
      pending_width_r <= pending_width_nxt;
      bits_gathered_r <= bits_gathered_nxt;
      field_accum_r   <= field_accum_nxt;
      consumed_r      <= consumed_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    out_field_r  <= out_field_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  `MFBR_ASSERT_NOW(a_cache_bound, 1'b1, bits_left_r <= LEFT_BITS'(BYTE_BITS),
    "byte cache holds more than one byte of bits")
  `MFBR_ASSERT_NOW(a_gather_bound, state_r == S_DRAIN,
    bits_gathered_r <= pending_width_r, "gathered more bits than requested")
  `MFBR_ASSERT_NOW(a_error_zero, out_valid_r && out_status_r != ST_OK,
    out_field_r == '0, "error result carries a nonzero field")
  `MFBR_ASSERT_NEXT(a_count_hold, state_r != S_DRAIN, $stable(consumed_r),
    "bit position moved outside the drain state")

endmodule

`default_nettype wire
